// ===== src/dlbp_pkg.sv =====
// ---------------------------------------------------------------------------
// dlbp_pkg
// Shared types and constants for the depth linearisation and back-projection
// core.
// ---------------------------------------------------------------------------
package dlbp_pkg;

    localparam int DEF_IMAGE_WIDTH  = 640;
    localparam int DEF_IMAGE_HEIGHT = 480;

    localparam logic [23:0] FULL_SCALE = 24'hFFFFFF;
    localparam int OFF_W   = 14;
    localparam int NSTAGE  = 24;
    localparam int ST_MUL  = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_NUM  = 3;
    localparam int ST_SAT  = 4;
    localparam int ST_DIVL = 20;
    localparam int ST_WIN  = 21;
    localparam int ST_PROJ = 22;
    localparam int ST_OUT  = 23;

    localparam logic [2:0] REG_NEAR   = 3'd0;
    localparam logic [2:0] REG_FAR    = 3'd1;
    localparam logic [2:0] REG_ZFAR   = 3'd2;
    localparam logic [2:0] REG_MIN    = 3'd3;
    localparam logic [2:0] REG_MAX    = 3'd4;
    localparam logic [2:0] REG_IFX    = 3'd5;
    localparam logic [2:0] REG_IFY    = 3'd6;
    localparam logic [2:0] REG_STRIDE = 3'd7;

    typedef struct packed {
        logic [23:0] smp;
        logic [8:0]  row;
        logic [9:0]  col;
        logic [63:0] nf;
        logic [55:0] fe;
        logic [55:0] ns;
        logic [56:0] den;
        logic [87:0] nfd;
        logic [89:0] num;
        logic [66:0] b;
        logic        zero;
        logic        sat;
        logic [15:0] q;
        logic [7:0]  rrem;
        logic [7:0]  crem;
        logic [15:0] depth;
        logic        valid;
        logic        grid;
        logic        nx;
        logic        ny;
        logic [29:0] mx;
        logic [29:0] my;
        logic [61:0] px;
        logic [61:0] py;
        logic [31:0] ox;
        logic [31:0] oy;
    } pipe_t;

endpackage

// ===== src/depth_linearize_backproject_core.sv =====
// ---------------------------------------------------------------------------
// depth_linearize_backproject_core
// Depth-buffer linearisation to millimetres and pinhole back-projection.
// ---------------------------------------------------------------------------
// Takes one pixel word per clock while the output is not stalled and returns
// one result word per pixel, in order. Most of the pipeline is the 16 stages of
// the restoring divider that turns the depth quotient into millimetres, one
// quotient bit a stage; the stride remainders run alongside in those stages.
// Empty stages close up under output backpressure.
module depth_linearize_backproject_core import dlbp_pkg::*; #(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // depth_sample[23:0], source_row[32:24], pixel_col[42:33]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // depth_mm[15:0], image_row[24:16], image_col[34:25],
                                    // point_x_mm[66:35], point_y_mm[98:67]
    output logic [1:0]   m_tuser,   // point_valid[0], on_cloud_grid[1]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [31:0] near_reg, far_reg, ifx_reg, ify_reg;
    logic        zfar_reg;
    logic [15:0] min_reg, max_reg;
    logic [7:0]  stride_reg;
    logic [7:0]  stride;
    logic        wr_en;

    pipe_t       pipe_reg  [NSTAGE];
    pipe_t       pipe_next [NSTAGE];
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign stride = (stride_reg == 8'd0) ? 8'd1 : stride_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg   <= 32'd10000;
            far_reg    <= 32'd50000000;
            zfar_reg   <= 1'b0;
            min_reg    <= 16'd0;
            max_reg    <= 16'hFFFF;
            ifx_reg    <= 32'd9224500;
            ify_reg    <= 32'd9210600;
            stride_reg <= 8'd1;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_NEAR:   near_reg   <= pwdata;
                REG_FAR:    far_reg    <= pwdata;
                REG_ZFAR:   zfar_reg   <= pwdata[0];
                REG_MIN:    min_reg    <= pwdata[15:0];
                REG_MAX:    max_reg    <= pwdata[15:0];
                REG_IFX:    ifx_reg    <= pwdata;
                REG_IFY:    ify_reg    <= pwdata;
                REG_STRIDE: stride_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_NEAR:   prdata = near_reg;
            REG_FAR:    prdata = far_reg;
            REG_ZFAR:   prdata = {31'd0, zfar_reg};
            REG_MIN:    prdata = {16'd0, min_reg};
            REG_MAX:    prdata = {16'd0, max_reg};
            REG_IFX:    prdata = ifx_reg;
            REG_IFY:    prdata = ify_reg;
            REG_STRIDE: prdata = {24'd0, stride_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // advance a stage when it is empty or its successor advances
    always_comb begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= s_tvalid;
            for (int i = 1; i < NSTAGE; i++) begin
                if (en[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
        if (i == 0) begin : g_in
            logic [12:0] row_w;
            always_comb begin
                row_w = 13'(IMAGE_HEIGHT - 1) - {4'd0, s_tdata[32:24]};
                pipe_next[i]     = '0;
                pipe_next[i].smp = zfar_reg ? (FULL_SCALE - s_tdata[23:0]) : s_tdata[23:0];
                pipe_next[i].row = row_w[8:0];
                pipe_next[i].col = s_tdata[42:33];
            end
        end else if (i == ST_MUL) begin : g_mul
            always_comb begin
                pipe_next[i]    = pipe_reg[i-1];
                pipe_next[i].nf = near_reg * far_reg;
                pipe_next[i].fe = far_reg * (FULL_SCALE - pipe_reg[i-1].smp);
                pipe_next[i].ns = near_reg * pipe_reg[i-1].smp;
            end
        end else if (i == ST_SUM) begin : g_sum
            always_comb begin
                pipe_next[i]     = pipe_reg[i-1];
                pipe_next[i].den = {1'b0, pipe_reg[i-1].fe} + {1'b0, pipe_reg[i-1].ns};
                pipe_next[i].nfd = {pipe_reg[i-1].nf, 24'd0} - {24'd0, pipe_reg[i-1].nf};
            end
        end else if (i == ST_NUM) begin : g_num
            always_comb begin
                pipe_next[i]      = pipe_reg[i-1];
                pipe_next[i].num  = {2'd0, pipe_reg[i-1].nfd}
                                  + ({33'd0, pipe_reg[i-1].den} * 90'd500);
                pipe_next[i].b    = {10'd0, pipe_reg[i-1].den} * 67'd1000;
                pipe_next[i].zero = (pipe_reg[i-1].den == 57'd0);
            end
        end else if (i == ST_SAT) begin : g_sat
            always_comb begin
                pipe_next[i]     = pipe_reg[i-1];
                pipe_next[i].sat = pipe_reg[i-1].num >= {7'd0, pipe_reg[i-1].b, 16'd0};
                pipe_next[i].q    = '0;
                pipe_next[i].rrem = '0;
                pipe_next[i].crem = '0;
            end
        end else if (i <= ST_DIVL) begin : g_div
            localparam int K = ST_DIVL - i;
            logic [89:0] t;
            logic [8:0]  rr, cr;
            logic [15:0] rx, cx;
            always_comb begin
                pipe_next[i] = pipe_reg[i-1];
                t = {23'd0, pipe_reg[i-1].b} << K;
                if (pipe_reg[i-1].num >= t) begin
                    pipe_next[i].num  = pipe_reg[i-1].num - t;
                    pipe_next[i].q[K] = 1'b1;
                end
                rx = {7'd0, pipe_reg[i-1].row};
                cx = {6'd0, pipe_reg[i-1].col};
                rr = {pipe_reg[i-1].rrem, rx[K]};
                cr = {pipe_reg[i-1].crem, cx[K]};
                if (rr >= {1'b0, stride}) rr = rr - {1'b0, stride};
                if (cr >= {1'b0, stride}) cr = cr - {1'b0, stride};
                pipe_next[i].rrem = rr[7:0];
                pipe_next[i].crem = cr[7:0];
            end
        end else if (i == ST_WIN) begin : g_win
            logic [15:0] d;
            logic signed [OFF_W-1:0] offx, offy;
            logic [OFF_W-1:0] ax, ay;
            always_comb begin
                pipe_next[i] = pipe_reg[i-1];
                if (pipe_reg[i-1].zero)     d = 16'd0;
                else if (pipe_reg[i-1].sat) d = 16'hFFFF;
                else                        d = pipe_reg[i-1].q;
                if (d < min_reg || d > max_reg) d = 16'd0;
                offx = $signed({3'd0, pipe_reg[i-1].col, 1'b0}) - OFF_W'(IMAGE_WIDTH - 1);
                offy = $signed({4'd0, pipe_reg[i-1].row, 1'b0}) - OFF_W'(IMAGE_HEIGHT - 1);
                ax = offx[OFF_W-1] ? OFF_W'(-offx) : offx;
                ay = offy[OFF_W-1] ? OFF_W'(-offy) : offy;
                pipe_next[i].depth = d;
                pipe_next[i].valid = (d != 16'd0);
                pipe_next[i].grid  = (pipe_reg[i-1].rrem == 8'd0) &&
                                     (pipe_reg[i-1].crem == 8'd0);
                pipe_next[i].nx    = offx[OFF_W-1];
                pipe_next[i].ny    = offy[OFF_W-1];
                pipe_next[i].mx    = 30'(ax * d);
                pipe_next[i].my    = 30'(ay * d);
            end
        end else if (i == ST_PROJ) begin : g_proj
            always_comb begin
                pipe_next[i]    = pipe_reg[i-1];
                pipe_next[i].px = pipe_reg[i-1].mx * ifx_reg;
                pipe_next[i].py = pipe_reg[i-1].my * ify_reg;
            end
        end else begin : g_out
            logic [31:0] qx, qy;
            always_comb begin
                pipe_next[i] = pipe_reg[i-1];
                // magnitude stays below 2^30, so no int32 clipping arises
                qx = {3'd0, pipe_reg[i-1].px[61:33]} + {31'd0, pipe_reg[i-1].px[32]};
                qy = {3'd0, pipe_reg[i-1].py[61:33]} + {31'd0, pipe_reg[i-1].py[32]};
                if (!pipe_reg[i-1].valid) begin
                    pipe_next[i].ox = 32'd0;
                    pipe_next[i].oy = 32'd0;
                end else begin
                    pipe_next[i].ox = pipe_reg[i-1].nx ? (32'd0 - qx) : qx;
                    pipe_next[i].oy = pipe_reg[i-1].ny ? (32'd0 - qy) : qy;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[i]) pipe_reg[i] <= pipe_next[i];
        end
    end

    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = {5'd0, pipe_reg[ST_OUT].oy, pipe_reg[ST_OUT].ox,
                       pipe_reg[ST_OUT].col, pipe_reg[ST_OUT].row, pipe_reg[ST_OUT].depth};
    assign m_tuser  = {pipe_reg[ST_OUT].grid, pipe_reg[ST_OUT].valid};

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[98:35] == 64'd0))
        else $error("invalid point carries nonzero coordinates");

    a_valid_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (m_tdata[15:0] != 16'd0)))
        else $error("point_valid disagrees with depth");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_WIN] && !en[ST_PROJ]) |=> valid_reg[ST_WIN])
        else $error("stage word dropped under stall");

endmodule
